>>> rtl/signed_radix_digit_emitter_unit_assert.svh
// assertion macros for the signed radix digit emitter
`ifndef SIGNED_RADIX_DIGIT_EMITTER_UNIT_ASSERT_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SRDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SRDE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/srde_pkg.sv
// shared constants and types of the signed radix digit emitter
package srde_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CELLS     = VALUE_W;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned ALPHA_W   = 128;
  localparam int unsigned ALPHA_N   = ALPHA_W / CHAR_W;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned MAX_RADIX = 16;

  localparam logic [CHAR_W-1:0]  CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CH_PLUS  = 8'h2B;

  localparam logic [RADIX_W-1:0] RST_DIGIT_COUNT = 5'd2;
  localparam logic [CFG_W-1:0]   RST_DIGITS_LOW  = 64'd12592;
  localparam logic [CFG_W-1:0]   RST_DIGITS_HIGH = 64'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIGIT_COUNT = 2'd0,
    REG_DIGITS_LOW  = 2'd1,
    REG_DIGITS_HIGH = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> rtl/srde_cell.sv
// one digit cell: doubles its digit with carry in the conversion wave, shifts in emission
module srde_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  srde_pkg::cell_ctrl_t             ctrl_i,
  input  logic [srde_pkg::RADIX_W-1:0]     radix_i,
  input  logic                             en_i,
  input  logic                             carry_i,
  input  logic [srde_pkg::DIGIT_W-1:0]     digit_i,
  output logic [srde_pkg::DIGIT_W-1:0]     digit_o,
  output logic                             en_o,
  output logic                             carry_o
);

  logic [srde_pkg::DIGIT_W-1:0] digit_q, digit_d;
  logic                         en_q, en_d;
  logic                         carry_q, carry_d;
  logic [srde_pkg::RADIX_W-1:0] sum;
  logic [srde_pkg::RADIX_W-1:0] diff;
  logic                         ge;

  assign sum  = {digit_q, carry_i};
  assign ge   = sum >= radix_i;
  assign diff = sum - radix_i;

  always_comb begin
    digit_d = digit_q;
    en_d    = 1'b0;
    carry_d = 1'b0;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end else if (en_i) begin
      en_d    = 1'b1;
      carry_d = ge;
      digit_d = ge ? diff[srde_pkg::DIGIT_W-1:0] : sum[srde_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      carry_q <= 1'b0;
    end else begin
      en_q    <= en_d;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;
  assign en_o    = en_q;
  assign carry_o = carry_q;

endmodule

>>> rtl/srde_alpha_check.sv
// alphabet validity: radix range, forbidden characters, repeated characters
module srde_alpha_check (
  input  logic [srde_pkg::RADIX_W-1:0] count_i,
  input  logic [srde_pkg::ALPHA_W-1:0] alpha_i,
  output logic                         ok_o
);

  always_comb begin
    logic [srde_pkg::CHAR_W-1:0] c;
    ok_o = (count_i >= 5'd2) && (count_i <= 5'(srde_pkg::MAX_RADIX));
    for (int i = 0; i < srde_pkg::ALPHA_N; i++) begin
      c = alpha_i[i*srde_pkg::CHAR_W +: srde_pkg::CHAR_W];
      if (5'(i) < count_i) begin
        if (c == '0 || c == srde_pkg::CH_MINUS || c == srde_pkg::CH_PLUS) begin
          ok_o = 1'b0;
        end
        for (int j = i + 1; j < srde_pkg::ALPHA_N; j++) begin
          if (5'(j) < count_i &&
              alpha_i[j*srde_pkg::CHAR_W +: srde_pkg::CHAR_W] == c) begin
            ok_o = 1'b0;
          end
        end
      end
    end
  end

endmodule

>>> rtl/signed_radix_digit_emitter_unit.sv
// top level: signed integer to text in a configured base, one character per item
//
// usage
//   s_axis takes one signed 32-bit value per item; m_axis returns its text, most
//   significant digit first, a leading minus for negative values, tlast on the
//   final character. the cfg port writes digit_count, digits_low and digits_high
//   (indexes 0, 1, 2); write them only while the block is idle (not enforced).
// timing
//   a row of 32 digit cells doubles-and-adds the magnitude one bit per cycle;
//   the carry wave moves one cell per cycle. leading zero digits are then
//   shifted out at one per cycle, and the characters leave at one per cycle
//   while the receiver is ready. with an invalid alphabet the item is dropped
//   in its accept cycle.
// reset and stall
//   reset restores the binary alphabet "01" and empties the pipeline. a
//   stalled receiver holds the output register and freezes emission; the next
//   value is taken while the final character still waits.
module signed_radix_digit_emitter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [srde_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [srde_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [srde_pkg::VALUE_W-1:0]      s_axis_tdata,   // value
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [srde_pkg::CHAR_W-1:0]       m_axis_tdata,   // character
  output logic                              m_axis_tlast
);

  logic [srde_pkg::RADIX_W-1:0] count_q;
  logic [srde_pkg::CFG_W-1:0]   low_q;
  logic [srde_pkg::CFG_W-1:0]   high_q;
  logic [srde_pkg::ALPHA_W-1:0] alpha;
  logic                         alpha_ok;

  srde_pkg::state_e             state_q, state_d;
  logic [srde_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [srde_pkg::CNT_W-1:0]   rem_q, rem_d;
  logic [srde_pkg::VALUE_W-1:0] mag_q, mag_d;
  logic                         neg_q, neg_d;

  logic                         mvalid_q, mvalid_d;
  logic [srde_pkg::CHAR_W-1:0]  mdata_q, mdata_d;
  logic                         mlast_q, mlast_d;

  srde_pkg::cell_ctrl_t         cell_ctrl;
  logic [srde_pkg::DIGIT_W-1:0] digit [srde_pkg::CELLS];
  logic                         en    [srde_pkg::CELLS+1];
  logic                         carry [srde_pkg::CELLS+1];
  logic [srde_pkg::DIGIT_W-1:0] top_digit;
  logic [srde_pkg::CHAR_W-1:0]  top_char;
  logic                         s_acc;
  logic                         load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= srde_pkg::RST_DIGIT_COUNT;
      low_q   <= srde_pkg::RST_DIGITS_LOW;
      high_q  <= srde_pkg::RST_DIGITS_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srde_pkg::REG_DIGIT_COUNT: count_q <= cfg_wdata_i[srde_pkg::RADIX_W-1:0];
        srde_pkg::REG_DIGITS_LOW:  low_q   <= cfg_wdata_i;
        srde_pkg::REG_DIGITS_HIGH: high_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign alpha = {high_q, low_q};

  srde_alpha_check u_alpha (
    .count_i (count_q),
    .alpha_i (alpha),
    .ok_o    (alpha_ok)
  );

  // digit cell row
  assign en[0]    = (state_q == srde_pkg::ST_CONV) &&
                    (cnt_q < srde_pkg::CNT_W'(srde_pkg::CELLS));
  assign carry[0] = mag_q[srde_pkg::VALUE_W-1];

  for (genvar k = 0; k < srde_pkg::CELLS; k++) begin : g_cell
    logic [srde_pkg::DIGIT_W-1:0] digit_in;
    if (k == 0) begin : g_first
      assign digit_in = '0;
    end else begin : g_rest
      assign digit_in = digit[k-1];
    end
    srde_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .radix_i (count_q),
      .en_i    (en[k]),
      .carry_i (carry[k]),
      .digit_i (digit_in),
      .digit_o (digit[k]),
      .en_o    (en[k+1]),
      .carry_o (carry[k+1])
    );
  end

  assign top_digit = digit[srde_pkg::CELLS-1];
  assign top_char  = alpha[{top_digit, 3'b000} +: srde_pkg::CHAR_W];

  assign s_axis_tready = (state_q == srde_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign load          = (state_q == srde_pkg::ST_SIGN || state_q == srde_pkg::ST_EMIT) &&
                         (!mvalid_q || m_axis_tready);

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    rem_d           = rem_q;
    mag_d           = mag_q;
    neg_d           = neg_q;
    mvalid_d        = mvalid_q && !m_axis_tready;
    mdata_d         = mdata_q;
    mlast_d         = mlast_q;
    cell_ctrl.clear = 1'b0;
    cell_ctrl.shift = 1'b0;
    case (state_q)
      srde_pkg::ST_IDLE: begin
        if (s_acc && alpha_ok) begin
          neg_d           = s_axis_tdata[srde_pkg::VALUE_W-1];
          mag_d           = neg_d ? (srde_pkg::VALUE_W'(0) - s_axis_tdata) : s_axis_tdata;
          cnt_d           = '0;
          cell_ctrl.clear = 1'b1;
          state_d         = srde_pkg::ST_CONV;
        end
      end
      srde_pkg::ST_CONV: begin
        mag_d = {mag_q[srde_pkg::VALUE_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == srde_pkg::CNT_W'(2 * srde_pkg::CELLS - 2)) begin
          rem_d   = srde_pkg::CNT_W'(srde_pkg::CELLS);
          state_d = srde_pkg::ST_SKIP;
        end
      end
      srde_pkg::ST_SKIP: begin
        if (top_digit == '0 && rem_q > srde_pkg::CNT_W'(1)) begin
          cell_ctrl.shift = 1'b1;
          rem_d           = rem_q - 1'b1;
        end else begin
          state_d = neg_q ? srde_pkg::ST_SIGN : srde_pkg::ST_EMIT;
        end
      end
      srde_pkg::ST_SIGN: begin
        if (load) begin
          mvalid_d = 1'b1;
          mdata_d  = srde_pkg::CH_MINUS;
          mlast_d  = 1'b0;
          state_d  = srde_pkg::ST_EMIT;
        end
      end
      srde_pkg::ST_EMIT: begin
        if (load) begin
          mvalid_d        = 1'b1;
          mdata_d         = top_char;
          mlast_d         = (rem_q == srde_pkg::CNT_W'(1));
          cell_ctrl.shift = 1'b1;
          rem_d           = rem_q - 1'b1;
          if (rem_q == srde_pkg::CNT_W'(1)) begin
            state_d = srde_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = srde_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= srde_pkg::ST_IDLE;
      cnt_q    <= '0;
      rem_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    mdata_q <= mdata_d;
    mlast_q <= mlast_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tlast  = mlast_q;

endmodule

>>> rtl/srde_checker.sv
// port-level checks of the signed radix digit emitter, bound to the top level
`include "signed_radix_digit_emitter_unit_assert.svh"

module srde_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [srde_pkg::CHAR_W-1:0]    m_axis_tdata,
  input logic                           m_axis_tlast
);

  logic s_acc;
  logic m_stall;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  `SRDE_ASSERT_NXT(a_out_hold, m_stall,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
                   "stalled output item changed")

  `SRDE_ASSERT_IMP(a_busy_mid_number, m_axis_tvalid && !m_axis_tlast, !s_axis_tready,
                   "input taken while a number is still being emitted")

  `SRDE_ASSERT_NXT(a_no_early_output, s_acc, !m_axis_tvalid || m_axis_tlast,
                   "output item appeared right after an input item")

endmodule

bind signed_radix_digit_emitter_unit srde_checker u_srde_checker (.*);

>>> test/tb_signed_radix_digit_emitter_unit.sv
// self-checking bench for the signed radix digit emitter: directed table, random alphabets
`timescale 1ns / 100ps

module tb_signed_radix_digit_emitter_unit;

  localparam int          N_ITEMS      = 310;
  localparam int          N_ROWS       = 43;
  localparam int          DRAIN_CYCLES = 120;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [1:0]    idx;
    logic [63:0]   data;
    logic [31:0]   value;
    int            n_chars;   // -1: use the text predictor
    logic [127:0]  text;      // last character in the low byte
  } stim_row_t;

  typedef struct {
    logic [srde_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } char_item_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [srde_pkg::CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [srde_pkg::CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [srde_pkg::VALUE_W-1:0]   s_axis_tdata  = '0;   // value
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [srde_pkg::CHAR_W-1:0]    m_axis_tdata;         // character
  logic                           m_axis_tlast;

  signed_radix_digit_emitter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the alphabet registers
  logic [srde_pkg::RADIX_W-1:0] radix_sh     = srde_pkg::RST_DIGIT_COUNT;
  logic [srde_pkg::CFG_W-1:0]   glyphs_lo_sh = srde_pkg::RST_DIGITS_LOW;
  logic [srde_pkg::CFG_W-1:0]   glyphs_hi_sh = srde_pkg::RST_DIGITS_HIGH;

  char_item_t  pending_chars[$];
  char_item_t  oldest;
  int          n_errors     = 0;
  int          n_converted  = 0;
  int          n_dropped    = 0;
  int          n_chars_seen = 0;
  int          n_alphabets  = 0;
  int          idle_mode    = 0;
  bit          hold_pending = 1'b0;
  bit          hold_on      = 1'b0;
  bit          in_flight    = 1'b0;
  int unsigned cycles       = 0;
  stim_row_t   dir_tbl [N_ROWS];

  function automatic stim_row_t item_row(input logic [31:0] v, input int n,
                                         input logic [127:0] text);
    stim_row_t r;
    r = '{kind: ROW_ITEM, idx: '0, data: '0, value: v, n_chars: n, text: text};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [63:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, value: '0, n_chars: 0, text: '0};
    return r;
  endfunction

  function automatic bit alphabet_valid();
    logic [127:0] g;
    int unsigned  n;
    g = {glyphs_hi_sh, glyphs_lo_sh};
    n = radix_sh;
    if (n < 2 || n > srde_pkg::MAX_RADIX) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (g[8*i +: 8] == 8'h00 || g[8*i +: 8] == srde_pkg::CH_MINUS ||
          g[8*i +: 8] == srde_pkg::CH_PLUS)
        return 1'b0;
      for (int j = i + 1; j < n; j++)
        if (g[8*j +: 8] == g[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_text(input logic [31:0] v);
    logic [127:0] g;
    logic [31:0]  mag;
    int unsigned  radix;
    int unsigned  rev [32];
    int           nd;
    g     = {glyphs_hi_sh, glyphs_lo_sh};
    radix = radix_sh;
    mag   = v[31] ? 32'd0 - v : v;
    nd    = 0;
    do begin
      rev[nd] = mag % radix;
      nd++;
      mag = mag / radix;
    end while (mag != 0 && nd < 32);
    if (v[31]) pending_chars.push_back('{ch: srde_pkg::CH_MINUS, last: 1'b0});
    for (int i = nd - 1; i >= 0; i--)
      pending_chars.push_back('{ch: g[8*rev[i] +: 8], last: (i == 0)});
  endfunction

  function automatic bit sender_idles();
    int pct;
    pct = (idle_mode == 0) ? 22 : (idle_mode == 1) ? 68 : 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  // leaves the write enable high; the next item lowers it
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      srde_pkg::REG_DIGIT_COUNT: radix_sh     = data[srde_pkg::RADIX_W-1:0];
      srde_pkg::REG_DIGITS_LOW:  glyphs_lo_sh = data;
      srde_pkg::REG_DIGITS_HIGH: glyphs_hi_sh = data;
      default: ;
    endcase
  endtask

  task automatic push_value(input logic [31:0] v, input bit predicted);
    cfg_we_i <= 1'b0;
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    in_flight = 1'b1;
    if (alphabet_valid()) n_converted++;
    else n_dropped++;
    if (predicted && alphabet_valid()) predict_text(v);
  endtask

  // idle the block before a register write or the end of the run
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    if (in_flight) begin
      while (pending_chars.size() != 0) @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      in_flight = 1'b0;
    end
  endtask

  task automatic program_alphabet(input bit broken);
    logic [127:0] glyphs;
    bit           used [256];
    int unsigned  radix;
    int unsigned  pos;
    int unsigned  c;
    case ($urandom_range(0, 3))
      0:       radix = 2;
      1:       radix = srde_pkg::MAX_RADIX;
      default: radix = $urandom_range(2, srde_pkg::MAX_RADIX);
    endcase
    glyphs = {$urandom, $urandom, $urandom, $urandom};
    used   = '{default: 1'b0};
    for (int d = 0; d < radix; d++) begin
      do c = $urandom_range(1, 255);
      while (c == srde_pkg::CH_MINUS || c == srde_pkg::CH_PLUS || used[c]);
      used[c] = 1'b1;
      glyphs[8*d +: 8] = c[7:0];
    end
    if (broken) begin
      pos = $urandom_range(0, radix - 1);
      case ($urandom_range(0, 4))
        0:       radix = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
        1:       glyphs[8*pos +: 8] = srde_pkg::CH_PLUS;
        2:       glyphs[8*pos +: 8] = srde_pkg::CH_MINUS;
        3:       glyphs[8*pos +: 8] = 8'h00;
        default: glyphs[8*pos +: 8] = glyphs[8*((pos + 1) % radix) +: 8];
      endcase
    end
    write_reg(srde_pkg::REG_DIGIT_COUNT, 64'(radix));
    write_reg(srde_pkg::REG_DIGITS_LOW, glyphs[63:0]);
    write_reg(srde_pkg::REG_DIGITS_HIGH, glyphs[127:64]);
    n_alphabets++;
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] p;
    logic [31:0] v;
    int unsigned radix;
    radix = (radix_sh < 2) ? 2 : radix_sh;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6:          v = $urandom_range(0, 300);
      7: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h7FFF_FFFF;
          4:       v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      8: begin
        p = 1;
        repeat ($urandom_range(1, 31))
          if (64'(p) * radix < 64'h8000_0000) p = p * radix;
        v = p - $urandom_range(0, 1);
      end
      default: v = 32'd0 - $urandom_range(1, 300);
    endcase
    if ($urandom_range(0, 3) == 0) v = 32'd0 - v;
    return v;
  endfunction

  // output side: check each character, then choose the next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_chars_seen++;
        if (pending_chars.size() == 0) begin
          $error("unexpected character %02h (last %0b)", m_axis_tdata, m_axis_tlast);
          n_errors++;
        end else begin
          oldest = pending_chars.pop_front();
          if (m_axis_tdata !== oldest.ch) begin
            $error("character: expected %02h, got %02h", oldest.ch, m_axis_tdata);
            n_errors++;
          end
          if (m_axis_tlast !== oldest.last) begin
            $error("is_last: expected %0b, got %0b", oldest.last, m_axis_tlast);
            n_errors++;
          end
        end
      end
      if (hold_on) begin
        m_axis_tready <= 1'b0;
      end else begin
        case (idle_mode)
          0:       m_axis_tready <= ($urandom_range(0, 99) >= 68);
          1:       m_axis_tready <= ($urandom_range(0, 99) >= 22);
          default: m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  // long receiver stall, counted in cycles
  initial begin
    wait (hold_pending);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycles, pending_chars.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    bit broken;
    bit first;
    int n;

    dir_tbl = '{
      item_row(32'h0000_0000, 1, "0"),
      item_row(32'h0000_0001, 1, "1"),
      item_row(32'hFFFF_FFFF, 2, "-1"),
      item_row(32'h7FFF_FFFF, -1, ""),
      item_row(32'h8000_0000, -1, ""),
      cfg_row(srde_pkg::REG_DIGIT_COUNT, 64'd16),
      cfg_row(srde_pkg::REG_DIGITS_LOW, 64'h3736_3534_3332_3130),
      cfg_row(srde_pkg::REG_DIGITS_HIGH, 64'h4645_4443_4241_3938),
      cfg_row(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF),
      item_row(32'h7FFF_FFFF, 8, "7FFFFFFF"),
      item_row(32'h8000_0000, 9, "-80000000"),
      item_row(32'h0000_00FF, 2, "FF"),
      item_row(32'hFFFF_FFF0, 3, "-10"),
      cfg_row(srde_pkg::REG_DIGIT_COUNT, 64'd10),
      item_row(32'd12345, 5, "12345"),
      item_row(32'h8000_0001, 11, "-2147483647"),
      item_row(32'd9, 1, "9"),
      // upper write bits are ignored, radix 3
      cfg_row(srde_pkg::REG_DIGIT_COUNT, 64'hFFFF_FFFF_FFFF_FFE3),
      item_row(32'd100, -1, ""),
      item_row(32'hFFFF_FF9C, -1, ""),
      // invalid alphabets, no characters
      cfg_row(srde_pkg::REG_DIGIT_COUNT, 64'd1),
      item_row(32'd5, 0, ""),
      cfg_row(srde_pkg::REG_DIGIT_COUNT, 64'd0),
      item_row(32'd5, 0, ""),
      cfg_row(srde_pkg::REG_DIGIT_COUNT, 64'd17),
      item_row(32'd5, 0, ""),
      cfg_row(srde_pkg::REG_DIGIT_COUNT, 64'd31),
      item_row(32'd5, 0, ""),
      cfg_row(srde_pkg::REG_DIGIT_COUNT, 64'd3),
      cfg_row(srde_pkg::REG_DIGITS_LOW, 64'h0000_0000_0030_3130),
      item_row(32'd7, 0, ""),
      cfg_row(srde_pkg::REG_DIGITS_LOW, 64'h0000_0000_002B_3130),
      item_row(32'd7, 0, ""),
      cfg_row(srde_pkg::REG_DIGITS_LOW, 64'h0000_0000_002D_3130),
      item_row(32'd7, 0, ""),
      cfg_row(srde_pkg::REG_DIGITS_LOW, 64'h0000_0000_0000_3130),
      item_row(32'd7, 0, ""),
      // repeat across the two banks
      cfg_row(srde_pkg::REG_DIGIT_COUNT, 64'd16),
      cfg_row(srde_pkg::REG_DIGITS_LOW, 64'h3736_3534_3332_3130),
      cfg_row(srde_pkg::REG_DIGITS_HIGH, 64'h4645_4443_4241_3937),
      item_row(32'd7, 0, ""),
      cfg_row(srde_pkg::REG_DIGITS_HIGH, 64'h4645_4443_4241_3938),
      item_row(32'hFFFF_FFFF, 2, "-1")
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_ROWS; r++) begin
      if (dir_tbl[r].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tbl[r].idx, dir_tbl[r].data);
      end else begin
        push_value(dir_tbl[r].value, dir_tbl[r].n_chars < 0);
        for (int k = 0; k < dir_tbl[r].n_chars; k++)
          pending_chars.push_back('{ch: dir_tbl[r].text[8*(dir_tbl[r].n_chars - 1 - k) +: 8],
                                    last: (k == dir_tbl[r].n_chars - 1)});
      end
    end

    first = 1'b1;
    while (n_converted + n_dropped < N_ITEMS) begin
      idle_mode = (n_converted + n_dropped < N_ITEMS / 3) ? 0 :
                  (n_converted + n_dropped < 2 * N_ITEMS / 3) ? 1 : 2;
      settle();
      broken = !first && $urandom_range(0, 5) == 0;
      program_alphabet(broken);
      // long receiver stall while values keep coming
      if (first) hold_pending = 1'b1;
      n = broken ? 4 : first ? 16 : $urandom_range(8, 24);
      repeat (n) push_value(random_value(), 1'b1);
      first = 1'b0;
    end

    settle();
    $display("converted %0d values and dropped %0d under invalid alphabets",
             n_converted, n_dropped);
    $display("checked %0d characters across %0d random alphabets", n_chars_seen, n_alphabets);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
